// ===== rtl/hsc_pkg.sv =====
// Package for the host name syntax checker: widths, character codes, class type.
package hsc_pkg;

    localparam int CHAR_W      = 8;
    localparam int LABEL_MAX_W = 6;
    localparam int SUFFIX_W    = 4;
    localparam int LABEL_CNT_W = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;
    localparam int OUT_DATA_W  = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LABEL_LEN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SUFFIX_LEN = 1'd1;

    // Reset values of the configuration registers
    localparam logic [LABEL_MAX_W-1:0] MAX_LABEL_LEN_RST  = 6'd63;
    localparam logic [SUFFIX_W-1:0]    MIN_SUFFIX_LEN_RST = 4'd2;

    // Saturation caps
    localparam logic [LABEL_CNT_W-1:0] LABEL_CAP  = 7'd127;
    localparam logic [SUFFIX_W-1:0]    SUFFIX_CAP = 4'd15;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ     = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ     = 8'h7A;

    // Class of one character
    typedef struct packed {
        logic letter;
        logic digit;
        logic hyphen;
        logic dot;
    } char_class_t;

endpackage

// ===== rtl/hsc_char_class.sv =====
// Character classifier: letter, digit, hyphen and dot flags for one code.
module hsc_char_class (
    input  logic [hsc_pkg::CHAR_W-1:0] char_code,
    output hsc_pkg::char_class_t       cls
);

    always_comb
    begin
        cls.letter = ((char_code >= hsc_pkg::CH_UA) && (char_code <= hsc_pkg::CH_UZ)) ||
                     ((char_code >= hsc_pkg::CH_LA) && (char_code <= hsc_pkg::CH_LZ));
        cls.digit  = (char_code >= hsc_pkg::CH_0) && (char_code <= hsc_pkg::CH_9);
        cls.hyphen = (char_code == hsc_pkg::CH_HYPHEN);
        cls.dot    = (char_code == hsc_pkg::CH_DOT);
    end

endmodule

// ===== rtl/hsc_state.sv =====
// Per-name parse state and verdict logic, updated once per processed item.
module hsc_state (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  hsc_pkg::char_class_t            cls,
    input  logic                            is_last,
    input  logic [hsc_pkg::LABEL_MAX_W-1:0] max_label_len,
    input  logic [hsc_pkg::SUFFIX_W-1:0]    min_suffix_len,
    output logic                            name_ok
);

    logic                            in_suffix_reg, in_suffix_next;
    logic [hsc_pkg::LABEL_CNT_W-1:0] label_count_reg, label_count_next;
    logic                            prev_hyphen_reg, prev_hyphen_next;
    logic [hsc_pkg::SUFFIX_W-1:0]    suffix_count_reg, suffix_count_next;
    logic                            failed_reg, failed_next;
    logic                            fail_final;

    // Parse step for one character
    always_comb
    begin
        in_suffix_next    = in_suffix_reg;
        label_count_next  = label_count_reg;
        prev_hyphen_next  = prev_hyphen_reg;
        suffix_count_next = suffix_count_reg;
        failed_next       = failed_reg;
        if (!in_suffix_reg)
        begin
            priority if (cls.dot)
            begin
                if ((label_count_reg == '0) ||
                    (label_count_reg > {1'b0, max_label_len}) || prev_hyphen_reg)
                begin
                    failed_next = 1'b1;
                end
                in_suffix_next    = 1'b1;
                suffix_count_next = '0;
            end
            else if (cls.letter || cls.digit || cls.hyphen)
            begin
                if ((label_count_reg == '0) && cls.hyphen)
                begin
                    failed_next = 1'b1;
                end
                if (label_count_reg < hsc_pkg::LABEL_CAP)
                begin
                    label_count_next = label_count_reg + 1'b1;
                end
                prev_hyphen_next = cls.hyphen;
            end
            else
            begin
                failed_next = 1'b1;
            end
        end
        else
        begin
            priority if (cls.dot)
            begin
                if (suffix_count_reg < min_suffix_len)
                begin
                    failed_next = 1'b1;
                end
                suffix_count_next = '0;
            end
            else if (cls.letter)
            begin
                if (suffix_count_reg < hsc_pkg::SUFFIX_CAP)
                begin
                    suffix_count_next = suffix_count_reg + 1'b1;
                end
            end
            else
            begin
                failed_next = 1'b1;
            end
        end
        // End-of-name check on the updated state
        fail_final = failed_next || !in_suffix_next || (suffix_count_next < min_suffix_len);
        name_ok    = !fail_final;
    end

    // State registers; cleared after every name
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_suffix_reg    <= 1'b0;
            label_count_reg  <= '0;
            prev_hyphen_reg  <= 1'b0;
            suffix_count_reg <= '0;
            failed_reg       <= 1'b0;
        end
        else if (step)
        begin
            if (is_last)
            begin
                in_suffix_reg    <= 1'b0;
                label_count_reg  <= '0;
                prev_hyphen_reg  <= 1'b0;
                suffix_count_reg <= '0;
                failed_reg       <= 1'b0;
            end
            else
            begin
                in_suffix_reg    <= in_suffix_next;
                label_count_reg  <= label_count_next;
                prev_hyphen_reg  <= prev_hyphen_next;
                suffix_count_reg <= suffix_count_next;
                failed_reg       <= failed_next;
            end
        end
    end

endmodule

// ===== rtl/hostname_syntax_checker_top.sv =====
// Top level of the host name syntax checker: input register, parser, result register.
// A verdict reaches m_tvalid once a name's last item has passed the input and result registers.
// Throughput: one item per cycle; the single parse stage between the input register and the
// result register sets that figure, and stalls only when a verdict is blocked by m_tready.
// Reset (rst_n, async, active low) clears the parse state and both valid flags, and loads
// max_label_len = 63 and min_suffix_len = 2.
module hostname_syntax_checker_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [hsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hsc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hsc_pkg::CHAR_W-1:0]          s_tdata,   // [7:0] char_code
    input  logic                                s_tlast,   // is_last
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hsc_pkg::OUT_DATA_W-1:0]      m_tdata    // [0] name_ok, [7:1] zero
);

    logic [hsc_pkg::LABEL_MAX_W-1:0] max_label_len_reg;
    logic [hsc_pkg::SUFFIX_W-1:0]    min_suffix_len_reg;

    logic                            in_valid_reg;
    logic [hsc_pkg::CHAR_W-1:0]      in_char_reg;
    logic                            in_last_reg;

    logic                            out_valid_reg;
    logic                            out_ok_reg;

    hsc_pkg::char_class_t            cls;
    logic                            name_ok;
    logic                            step;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_label_len_reg  <= hsc_pkg::MAX_LABEL_LEN_RST;
            min_suffix_len_reg <= hsc_pkg::MIN_SUFFIX_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hsc_pkg::REG_MAX_LABEL_LEN:
                    max_label_len_reg <= cfg_data;
                hsc_pkg::REG_MIN_SUFFIX_LEN:
                    min_suffix_len_reg <= cfg_data[hsc_pkg::SUFFIX_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // A held item moves on unless it is a last item facing a full, stalled result register
    assign step     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    hsc_char_class u_class (
        .char_code (in_char_reg),
        .cls       (cls)
    );

    hsc_state u_state (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .cls            (cls),
        .is_last        (in_last_reg),
        .max_label_len  (max_label_len_reg),
        .min_suffix_len (min_suffix_len_reg),
        .name_ok        (name_ok)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
        begin
            out_ok_reg <= name_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(hsc_pkg::OUT_DATA_W-1){1'b0}}, out_ok_reg};

endmodule

// ===== dv/hsc_tb_pkg.sv =====
// Scoreboard class for the host name syntax checker bench: verdict predictor and checker.
`timescale 1ns / 1ps
package hsc_tb_pkg;
    import hsc_pkg::*;

    class verdict_board;
        // register copies
        logic [LABEL_MAX_W-1:0] max_label_len;
        logic [SUFFIX_W-1:0]    min_suffix_len;

        // parse state of the name in flight
        logic                   in_suffix;
        logic [LABEL_CNT_W-1:0] label_count;
        logic                   prev_hyphen;
        logic [SUFFIX_W-1:0]    suffix_count;
        logic                   failed;

        // verdicts predicted but not yet seen on the result side
        logic                   verdict_q[$];

        int errors;
        int chars_seen;
        int names_seen;
        int names_valid;

        function new();
            max_label_len  = MAX_LABEL_LEN_RST;
            min_suffix_len = MIN_SUFFIX_LEN_RST;
            errors         = 0;
            chars_seen     = 0;
            names_seen     = 0;
            names_valid    = 0;
            clear_name();
        endfunction

        function void clear_name();
            in_suffix    = 1'b0;
            label_count  = '0;
            prev_hyphen  = 1'b0;
            suffix_count = '0;
            failed       = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MAX_LABEL_LEN)
                max_label_len = data[LABEL_MAX_W-1:0];
            else if (idx == REG_MIN_SUFFIX_LEN)
                min_suffix_len = data[SUFFIX_W-1:0];
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        // Advance the parse by one accepted character; queue a verdict on the last one
        function void note_char(logic [CHAR_W-1:0] c, logic last);
            logic letter;
            logic digit;
            logic hyphen;
            letter = (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
            digit  = (c >= CH_0 && c <= CH_9);
            hyphen = (c == CH_HYPHEN);
            chars_seen++;
            if (!in_suffix)
            begin
                if (c == CH_DOT)
                begin
                    // first label closes: 1..max long, no trailing hyphen
                    if (label_count == '0 || label_count > {1'b0, max_label_len} || prev_hyphen)
                        failed = 1'b1;
                    in_suffix    = 1'b1;
                    suffix_count = '0;
                end
                else if (letter || digit || hyphen)
                begin
                    if (label_count == '0 && hyphen)
                        failed = 1'b1;
                    if (label_count < LABEL_CAP)
                        label_count = label_count + 1'b1;
                    prev_hyphen = hyphen;
                end
                else
                    failed = 1'b1;
            end
            else
            begin
                if (c == CH_DOT)
                begin
                    if (suffix_count < min_suffix_len)
                        failed = 1'b1;
                    suffix_count = '0;
                end
                else if (letter)
                begin
                    if (suffix_count < SUFFIX_CAP)
                        suffix_count = suffix_count + 1'b1;
                end
                else
                    failed = 1'b1;
            end

            if (last)
            begin
                // name must have reached a suffix, and the final suffix must be long enough
                if (!in_suffix || suffix_count < min_suffix_len)
                    failed = 1'b1;
                verdict_q.push_back(!failed);
                names_seen++;
                if (!failed)
                    names_valid++;
                clear_name();
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        // Compare one accepted verdict item against the oldest prediction
        task check_verdict(logic [OUT_DATA_W-1:0] data);
            logic exp_ok;
            if (verdict_q.size() == 0)
                report_mismatch($sformatf("verdict %02h arrived with no name pending", data));
            else
            begin
                exp_ok = verdict_q.pop_front();
                if (data[0] !== exp_ok)
                    report_mismatch($sformatf("name_ok %b, predicted %b (name %0d)",
                                              data[0], exp_ok, names_seen - verdict_q.size()));
                if (data[OUT_DATA_W-1:1] !== '0)
                    report_mismatch($sformatf("tdata padding %02h is not zero", data));
            end
        endtask

        task finish_check();
            if (verdict_q.size() != 0)
                report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
        endtask
    endclass

endpackage

// ===== dv/hostname_syntax_checker_top_tb.sv =====
// Testbench top for the host name syntax checker: stream drivers, monitor, watchdog.
`timescale 1ns / 1ps
module hostname_syntax_checker_top_tb;
    import hsc_pkg::*;
    import hsc_tb_pkg::*;

    localparam int ITEMS_TARGET  = 1450;
    localparam int PHASE_CHARS   = 160;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 5000;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum int { NAME_CLEAN, NAME_BROKEN, NAME_NOISE } name_kind_t;

    typedef enum int {
        MUT_BYTE,
        MUT_LEAD_HYPHEN,
        MUT_TRAIL_HYPHEN,
        MUT_NO_SUFFIX,
        MUT_TRAIL_DOT,
        MUT_DOUBLE_DOT,
        MUT_EMPTY_LABEL,
        MUT_SUFFIX_DIGIT
    } mutation_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [CHAR_W-1:0]     s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;
    int idle_cycles    = 0;
    int cur_max_label  = MAX_LABEL_LEN_RST;
    int cur_min_suffix = MIN_SUFFIX_LEN_RST;
    int settings_used  = 1;
    int chars_sent     = 0;

    logic [CHAR_W-1:0] name_buf[$];
    verdict_board      board;

    hostname_syntax_checker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] char_code
        .s_tlast   (s_tlast),    // is_last
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)     // [0] name_ok, [7:1] zero
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int unsigned gap_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [CHAR_W-1:0] letter_char();
        int unsigned k;
        k = $urandom_range(0, 51);
        if (k < 26)
            return CH_UA + CHAR_W'(k);
        else
            return CH_LA + CHAR_W'(k - 26);
    endfunction

    function automatic logic [CHAR_W-1:0] alnum_char();
        int unsigned k;
        k = $urandom_range(0, 61);
        if (k < 52)
            return letter_char();
        else
            return CH_0 + CHAR_W'(k - 52);
    endfunction

    // Fill name_buf with one name of the given kind under the current settings
    function automatic void build_name(name_kind_t kind);
        int unsigned len;
        int unsigned slen;
        int unsigned r;
        int unsigned lab;
        string       pool;
        mutation_t   mut;
        pool = "aZ9.-";
        name_buf.delete();
        if (kind == NAME_NOISE)
        begin
            // any byte, with some legal characters mixed in
            len = $urandom_range(1, 8);
            repeat (len)
            begin
                if ($urandom_range(0, 1) == 0)
                    name_buf.push_back(CHAR_W'($urandom_range(0, 255)));
                else
                    name_buf.push_back(pool[$urandom_range(0, 4)]);
            end
        end
        else
        begin
            // first label: mostly short, sometimes around the limit, rarely around saturation
            r = $urandom_range(0, 99);
            if (r < 75)
                len = $urandom_range(1, (cur_max_label < 7) ? cur_max_label + 1 : 8);
            else if (r < 98)
                len = $urandom_range(1, cur_max_label + 2);
            else
                len = $urandom_range(120, 135);
            lab = len;
            for (int i = 0; i < len; i++)
            begin
                if (i != 0 && i != len - 1 && $urandom_range(0, 4) == 0)
                    name_buf.push_back(CH_HYPHEN);
                else
                    name_buf.push_back(alnum_char());
            end

            // suffixes: lengths around the minimum, now and then past the counter cap
            repeat ($urandom_range(1, 3))
            begin
                name_buf.push_back(CH_DOT);
                if ($urandom_range(0, 99) < 90)
                    slen = $urandom_range((cur_min_suffix > 0) ? cur_min_suffix - 1 : 0,
                                          cur_min_suffix + 2);
                else
                    slen = $urandom_range(13, 18);
                repeat (slen)
                    name_buf.push_back(letter_char());
            end

            if (kind == NAME_BROKEN)
            begin
                mut = mutation_t'($urandom_range(0, MUT_SUFFIX_DIGIT));
                case (mut)
                    MUT_BYTE:
                        name_buf[$urandom_range(0, name_buf.size() - 1)] =
                            CHAR_W'($urandom_range(0, 255));
                    MUT_LEAD_HYPHEN:  name_buf.push_front(CH_HYPHEN);
                    MUT_TRAIL_HYPHEN: name_buf.insert(lab, CH_HYPHEN);
                    MUT_NO_SUFFIX:
                        while (name_buf.size() > lab)
                            void'(name_buf.pop_back());
                    MUT_TRAIL_DOT:    name_buf.push_back(CH_DOT);
                    MUT_DOUBLE_DOT:   name_buf.insert(lab, CH_DOT);
                    MUT_EMPTY_LABEL:  name_buf.push_front(CH_DOT);
                    MUT_SUFFIX_DIGIT:
                        name_buf.insert(lab + 1, CH_0 + CHAR_W'($urandom_range(0, 9)));
                    default: ;
                endcase
            end
        end
    endfunction

    // Offer one item and hold it until accepted, then maybe leave a gap
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        int unsigned g;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        g = no_idle ? 0 : gap_cycles();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_name();
        foreach (name_buf[i])
            send_char(name_buf[i], i == name_buf.size() - 1);
        chars_sent += name_buf.size();
    endtask

    task automatic send_text(input string s);
        name_buf.delete();
        for (int i = 0; i < s.len(); i++)
            name_buf.push_back(s[i]);
        send_name();
    endtask

    // Write both registers back to back; unused data bits of the narrow one get noise
    task automatic write_settings(input int max_label, input int min_suffix);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        d[SUFFIX_W-1:0] = SUFFIX_W'(min_suffix);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_LABEL_LEN;
        cfg_data  <= CFG_DATA_W'(max_label);
        @(posedge clk);
        cfg_index <= REG_MIN_SUFFIX_LEN;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_max_label  = max_label;
        cur_min_suffix = min_suffix;
        settings_used++;
    endtask

    // Stop offering, wait for every predicted verdict, then let the pipe settle
    task automatic drain();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Monitor: sample handshakes at the edge, feed the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_verdict(m_tdata);
            if (cfg_we)
                board.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                board.note_char(s_tdata, s_tlast);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on cycles with no handshake
    initial
    begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random ready pattern, one long hold-off on request
    initial
    begin : receiver
        int unsigned g;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (no_idle)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                g = gap_cycles();
                if (g > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
        end
    end

    // Main sequence
    initial
    begin : stimulus
        int          p;
        int          phase_end;
        int unsigned r;
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed names under the reset settings
        send_text("a.zz");      // letter extremes, valid
        send_text("Z-9.AZ");    // inner hyphen and digit, valid
        send_text("a-.xy");     // label ends in hyphen
        send_text("-a.bc");     // label starts with hyphen
        send_text("0.a");       // suffix too short
        name_buf = '{8'h00};    // lowest code, alone
        send_name();
        name_buf = '{8'hFF};    // highest code, alone
        send_name();
        drain();

        // random phases, each under its own register settings
        p = 0;
        while (chars_sent < ITEMS_TARGET)
        begin
            case (p)
                0:       write_settings(1, 1);
                1:       write_settings(0, 0);
                2:       write_settings(63, 15);
                3:       write_settings(0, 15);
                4:       write_settings(1, 0);
                5:       write_settings(63, 0);
                default: write_settings($urandom_range(0, 63), $urandom_range(0, 15));
            endcase

            // first phase: back-to-back items against a stalled result side; fifth phase back-to-back too
            no_idle = (p == 0 || p == 4);
            if (p == 0)
                hold_req = 1'b1;

            phase_end = chars_sent + PHASE_CHARS;
            while (chars_sent < phase_end)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    build_name(NAME_CLEAN);
                else if (r < 90)
                    build_name(NAME_BROKEN);
                else
                    build_name(NAME_NOISE);
                send_name();
            end
            drain();
            no_idle = 1'b0;
            p++;
        end

        drain();
        board.finish_check();
        $display("covered %0d characters in %0d names (%0d valid) over %0d register settings",
                 board.chars_seen, board.names_seen, board.names_valid, settings_used);
        $display("random gaps on both sides, one long result-side hold-off, zero limits");
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hsc_pkg.sv
rtl/hsc_char_class.sv
rtl/hsc_state.sv
rtl/hostname_syntax_checker_top.sv
dv/hsc_tb_pkg.sv
dv/hostname_syntax_checker_top_tb.sv
